/* rtl/core/adsc_pkg.sv */
// Shared types and constants for the antenna delay search calibrator.
// No dependencies; imported by every module of the block.
package adsc_pkg;

    // Field widths
    localparam int RANGE_W  = 24;
    localparam int TARGET_W = 23;
    localparam int DELAY_W  = 16;
    localparam int STEP_W   = 7;
    localparam int TRIAL_W  = 7;
    localparam int SUM_W    = 23;
    localparam int CFG_A_W  = 2;
    localparam int CFG_D_W  = 23;

    // Calibration constants
    localparam int TRIAL_COUNT = 10;
    localparam logic [TRIAL_W-1:0] TRIAL_LIMIT = TRIAL_W'(TRIAL_COUNT);
    localparam logic [STEP_W-1:0]  INIT_STEP   = STEP_W'(100);
    localparam logic [STEP_W-1:0]  LIMIT_STEP  = STEP_W'(3);

    // Reset values of the configuration registers
    localparam logic [TARGET_W-1:0] TARGET_RST = TARGET_W'(300);
    localparam logic [DELAY_W-1:0]  START_RST  = DELAY_W'(16600);

    // Floor division of the trial sum by TRIAL_COUNT: multiply by a rounded-up
    // reciprocal, exact for every sum below 2^SUM_W.
    localparam int    DIV_LOG   = $clog2(TRIAL_COUNT);
    localparam int    DIV_SHIFT = SUM_W + DIV_LOG;
    localparam int    DIV_MUL_W = SUM_W + 1;
    localparam int    DIV_PROD_W = SUM_W + DIV_MUL_W;
    localparam longint DIV_MUL_L =
        ((longint'(1) << DIV_SHIFT) + longint'(TRIAL_COUNT) - 1) / longint'(TRIAL_COUNT);
    localparam logic [DIV_MUL_W-1:0] DIV_MUL = DIV_MUL_W'(DIV_MUL_L);

    // Configuration register indexes
    typedef enum logic [CFG_A_W-1:0] {
        CFG_MODE   = 2'd0,
        CFG_TARGET = 2'd1,
        CFG_START  = 2'd2
    } t_cfg_idx;

    // Result status codes
    typedef enum logic [1:0] {
        ST_NORMAL = 2'd0,
        ST_SEARCH = 2'd1,
        ST_TRIAL  = 2'd2,
        ST_DONE   = 2'd3
    } t_status;

    // Sign of the last range error
    typedef enum logic [1:0] {
        SIGN_NONE = 2'd0,
        SIGN_POS  = 2'd1,
        SIGN_NEG  = 2'd2
    } t_sign;

    typedef struct packed {
        logic                calibrate_mode;
        logic [TARGET_W-1:0] target_distance;
        logic [DELAY_W-1:0]  start_delay;
    } t_cfg;

    typedef struct packed {
        logic [DELAY_W-1:0]        antenna_delay;
        logic signed [RANGE_W-1:0] smoothed_range;
        t_status                   status;
        logic [TRIAL_W-1:0]        trials_done;
    } t_result;

endpackage

/* rtl/core/adsc_cfg_regs.sv */
// Configuration registers of the calibrator: mode, target distance, start delay.
// Depends on adsc_pkg.
module adsc_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [adsc_pkg::CFG_A_W-1:0] i_cfg_addr,
    input  logic [adsc_pkg::CFG_D_W-1:0] i_cfg_wr_data,
    output adsc_pkg::t_cfg               o_cfg,
    output logic                         o_mode_wr
);
    import adsc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic n_mode_wr;

    // Decode one register write
    always_comb begin
        n_cfg     = r_cfg;
        n_mode_wr = 1'b0;
        if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_MODE: begin
                    n_cfg.calibrate_mode = i_cfg_wr_data[0];
                    n_mode_wr            = 1'b1;
                end
                CFG_TARGET: n_cfg.target_distance = i_cfg_wr_data[TARGET_W-1:0];
                CFG_START:  n_cfg.start_delay     = i_cfg_wr_data[DELAY_W-1:0];
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.calibrate_mode  <= 1'b0;
            r_cfg.target_distance <= TARGET_RST;
            r_cfg.start_delay     <= START_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg     = r_cfg;
    assign o_mode_wr = n_mode_wr;

endmodule

/* rtl/core/adsc_update.sv */
// Per-item state update: smoothing average, delay search step, trial averaging.
// Holds the calibration state registers. Depends on adsc_pkg.
module adsc_update (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  adsc_pkg::t_cfg                      i_cfg,
    input  logic                                i_mode_wr,
    input  logic                                i_fire,
    input  logic signed [adsc_pkg::RANGE_W-1:0] i_range,
    output adsc_pkg::t_result                   o_result
);
    import adsc_pkg::*;

    logic [DELAY_W-1:0]        r_delay,     n_delay;
    logic                      r_loaded,    n_loaded;
    logic signed [RANGE_W-1:0] r_avg,       n_avg;
    logic [STEP_W-1:0]         r_step,      n_step;
    t_sign                     r_sign,      n_sign;
    logic [TRIAL_W-1:0]        r_trial_idx, n_trial_idx;
    logic [SUM_W-1:0]          r_trial_sum, n_trial_sum;
    logic                      r_finished,  n_finished;

    logic [DELAY_W-1:0]        delay_cur;
    logic signed [RANGE_W:0]   avg_sum;
    logic signed [RANGE_W:0]   err;
    t_sign                     err_sign;
    logic                      opposite;
    logic [STEP_W-1:0]         step_adj;
    logic [SUM_W-1:0]          sum_new;
    logic [TRIAL_W-1:0]        idx_new;
    logic [DIV_PROD_W-1:0]     div_prod;
    t_result                   res;

    // Shared datapath terms
    always_comb begin
        delay_cur = r_loaded ? r_delay : i_cfg.start_delay;
        avg_sum   = RANGE_W'(0) + {i_range[RANGE_W-1], i_range}
                    + {r_avg[RANGE_W-1], r_avg};
        err       = {i_range[RANGE_W-1], i_range}
                    - $signed({2'b00, i_cfg.target_distance});
        if (err > 0) begin
            err_sign = SIGN_POS;
        end else if (err < 0) begin
            err_sign = SIGN_NEG;
        end else begin
            err_sign = SIGN_NONE;
        end
        opposite = (err_sign == SIGN_POS && r_sign == SIGN_NEG) ||
                   (err_sign == SIGN_NEG && r_sign == SIGN_POS);
        step_adj = opposite ? (r_step >> 1) : r_step;
        sum_new  = r_trial_sum + SUM_W'(delay_cur);
        idx_new  = r_trial_idx + TRIAL_W'(1);
        div_prod = DIV_PROD_W'(sum_new) * DIV_PROD_W'(DIV_MUL);
    end

    // Next state and result for the item in the input stage
    always_comb begin
        n_delay     = r_delay;
        n_loaded    = r_loaded;
        n_avg       = r_avg;
        n_step      = r_step;
        n_sign      = r_sign;
        n_trial_idx = r_trial_idx;
        n_trial_sum = r_trial_sum;
        n_finished  = r_finished;

        res.smoothed_range = r_avg;
        res.trials_done    = r_trial_idx;
        res.status         = ST_NORMAL;
        res.antenna_delay  = delay_cur;

        if (!i_cfg.calibrate_mode || r_finished) begin
            // normal report
            n_avg              = avg_sum[RANGE_W:1];
            res.smoothed_range = avg_sum[RANGE_W:1];
        end else if (r_step < LIMIT_STEP) begin
            // trial recorded
            res.trials_done = idx_new;
            n_step          = INIT_STEP;
            n_sign          = SIGN_NONE;
            if (idx_new >= TRIAL_LIMIT) begin
                n_delay     = div_prod[DIV_SHIFT +: DELAY_W];
                res.status  = ST_DONE;
                n_finished  = 1'b1;
                n_trial_idx = '0;
                n_trial_sum = '0;
            end else begin
                n_delay     = i_cfg.start_delay;
                res.status  = ST_TRIAL;
                n_trial_idx = idx_new;
                n_trial_sum = sum_new;
            end
            res.antenna_delay = n_delay;
        end else begin
            // search step
            n_step     = step_adj;
            n_sign     = err_sign;
            res.status = ST_SEARCH;
            if (err_sign == SIGN_POS) begin
                n_delay = delay_cur + DELAY_W'(step_adj);
            end else begin
                n_delay = delay_cur - DELAY_W'(step_adj);
            end
            res.antenna_delay = n_delay;
        end

        // first item loads the start delay
        if (!r_loaded) begin
            n_loaded = 1'b1;
            if (n_delay == r_delay && res.status == ST_NORMAL) begin
                n_delay = delay_cur;
            end
        end
        if (res.status == ST_NORMAL) begin
            n_delay = delay_cur;
        end

        if (!i_fire) begin
            n_delay     = r_delay;
            n_loaded    = r_loaded;
            n_avg       = r_avg;
            n_step      = r_step;
            n_sign      = r_sign;
            n_trial_idx = r_trial_idx;
            n_trial_sum = r_trial_sum;
            n_finished  = r_finished;
        end
        if (i_mode_wr) begin
            n_finished = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay     <= '0;
            r_loaded    <= 1'b0;
            r_avg       <= '0;
            r_step      <= INIT_STEP;
            r_sign      <= SIGN_NONE;
            r_trial_idx <= '0;
            r_trial_sum <= '0;
            r_finished  <= 1'b0;
        end else begin
            r_delay     <= n_delay;
            r_loaded    <= n_loaded;
            r_avg       <= n_avg;
            r_step      <= n_step;
            r_sign      <= n_sign;
            r_trial_idx <= n_trial_idx;
            r_trial_sum <= n_trial_sum;
            r_finished  <= n_finished;
        end
    end

    assign o_result = res;

endmodule

/* rtl/core/antenna_delay_search_calibrator.sv */
// Antenna delay search calibrator, top level: input and result registers
// around the state update. Depends on adsc_pkg, adsc_cfg_regs, adsc_update.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one measured range in signed mm.
//   Result channel (o_valid / i_ready) returns exactly one result per range:
//   antenna delay, smoothed range, status and trials recorded so far.
//   Configuration registers are written through i_cfg_wr_en / i_cfg_addr /
//   i_cfg_wr_data, only while no transfer is in flight (index 0 mode,
//   1 target distance, 2 start delay; index 3 is ignored).
// Timing:
//   An accepted range lands in the input register; once the result register
//   is free or being taken, its result and state update are computed in one
//   pass into the result register, which raises o_valid. One range per cycle
//   is taken while the receiver holds i_ready; the one-pass update sets that rate.
// Reset (synchronous, active low): both stages empty, registers at defaults,
//   search state cleared.
// Receiver stall: the result register holds its transfer; the input register
//   still takes one more range, then o_ready drops until the result is taken.
module antenna_delay_search_calibrator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [adsc_pkg::RANGE_W-1:0] i_measured_range,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [adsc_pkg::DELAY_W-1:0]        o_antenna_delay,
    output logic signed [adsc_pkg::RANGE_W-1:0] o_smoothed_range,
    output logic [1:0]                          o_status,
    output logic [adsc_pkg::TRIAL_W-1:0]        o_trials_done,
    input  logic                                i_cfg_wr_en,
    input  logic [adsc_pkg::CFG_A_W-1:0]        i_cfg_addr,
    input  logic [adsc_pkg::CFG_D_W-1:0]        i_cfg_wr_data
);
    import adsc_pkg::*;

    t_cfg    cfg;
    logic    mode_wr;
    t_result result;
    logic    advance;

    logic                      r_in_valid;
    logic signed [RANGE_W-1:0] r_in_range;
    logic                      r_out_valid;
    t_result                   r_out;

    // Stage handshake
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    adsc_cfg_regs u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_cfg         (cfg),
        .o_mode_wr     (mode_wr)
    );

    adsc_update u_update (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_mode_wr (mode_wr),
        .i_fire    (advance),
        .i_range   (r_in_range),
        .o_result  (result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_range <= i_measured_range;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_antenna_delay  = r_out.antenna_delay;
    assign o_smoothed_range = r_out.smoothed_range;
    assign o_status         = r_out.status;
    assign o_trials_done    = r_out.trials_done;

endmodule

/* tb/tb_antenna_delay_search_calibrator.sv */
`timescale 1ns / 1ps
// Self-checking testbench for antenna_delay_search_calibrator: a directed table, then bursty
// random ranges, each result checked against its table value or an in-bench model of the delay search.
// Depends on adsc_pkg and the calibrator RTL.
module tb_antenna_delay_search_calibrator;
    import adsc_pkg::*;

    localparam int RANGE_MAX    = 8388607;
    localparam int TARGET_MAX   = 8388607;
    localparam int RANDOM_ITEMS = 1500;
    localparam int IDLE_LIMIT   = 2000;
    localparam int PRINT_LIMIT  = 100;
    localparam int END_WAIT     = 10;

    // Register index past the end of the map, must be ignored
    localparam logic [CFG_A_W-1:0] CFG_UNUSED = 2'd3;

    // Receiver stall styles
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} t_rx_style;

    // One row of the directed table: a register write or a range transfer
    typedef struct {
        bit                        is_cfg;
        logic [CFG_A_W-1:0]        addr;
        int unsigned               data;
        logic signed [RANGE_W-1:0] rng;
        bit                        typed;
        t_result                   want;
    } t_stim_row;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_ready;
    logic signed [RANGE_W-1:0]   i_measured_range = '0;
    logic                        o_valid;
    logic                        i_ready = 1'b0;
    logic [DELAY_W-1:0]          o_antenna_delay;
    logic signed [RANGE_W-1:0]   o_smoothed_range;
    logic [1:0]                  o_status;
    logic [TRIAL_W-1:0]          o_trials_done;
    logic                        i_cfg_wr_en = 1'b0;
    logic [CFG_A_W-1:0]          i_cfg_addr = '0;
    logic [CFG_D_W-1:0]          i_cfg_wr_data = '0;

    // Model copy of the registers and of the search state, at reset values
    logic                        cf_mode = 1'b0;
    logic [TARGET_W-1:0]         cf_target = TARGET_RST;
    logic [DELAY_W-1:0]          cf_start = START_RST;
    logic [DELAY_W-1:0]          md_delay = '0;
    logic                        md_loaded = 1'b0;
    logic signed [RANGE_W-1:0]   md_average = '0;
    logic [STEP_W-1:0]           md_step = INIT_STEP;
    t_sign                       md_last_sign = SIGN_NONE;
    logic [TRIAL_W-1:0]          md_trials = '0;
    logic [SUM_W-1:0]            md_sum = '0;
    logic                        md_finished = 1'b0;

    t_result                     pending_results[$];
    int                          mismatch_count = 0;
    int                          idle_cycles = 0;
    bit                          valid_up = 1'b0;
    bit                          search_above = 1'b0;
    t_rx_style                   rx_style = RX_OPEN;
    int                          rx_left = 0;
    int                          rx_phase = 0;

    antenna_delay_search_calibrator dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Expected result of one range; advances the model state
    function automatic t_result next_calibration_result(input logic signed [RANGE_W-1:0] rng);
        t_result                 res;
        logic signed [RANGE_W:0] total;
        int                      err;
        t_sign                   sgn;
        if (!md_loaded) begin
            md_delay  = cf_start;
            md_loaded = 1'b1;
        end
        if (!cf_mode || md_finished) begin
            // alpha one half average, floor of the halved sum
            total           = rng + md_average;
            md_average      = total[RANGE_W:1];
            res.status      = ST_NORMAL;
            res.trials_done = md_trials;
        end else if (md_step < LIMIT_STEP) begin
            // record one trial
            md_sum    = md_sum + SUM_W'(md_delay);
            md_trials = md_trials + 1'b1;
            res.trials_done = md_trials;
            if (md_trials >= TRIAL_LIMIT) begin
                md_delay     = DELAY_W'(md_sum / SUM_W'(TRIAL_COUNT));
                res.status   = ST_DONE;
                md_finished  = 1'b1;
                md_trials    = '0;
                md_sum       = '0;
                md_step      = INIT_STEP;
                md_last_sign = SIGN_NONE;
            end else begin
                md_delay     = cf_start;
                md_step      = INIT_STEP;
                md_last_sign = SIGN_NONE;
                res.status   = ST_TRIAL;
            end
        end else begin
            // search step: halve on a strict sign flip, then move toward the target
            err = int'(rng) - int'(cf_target);
            sgn = (err > 0) ? SIGN_POS : ((err < 0) ? SIGN_NEG : SIGN_NONE);
            if ((sgn == SIGN_POS && md_last_sign == SIGN_NEG) ||
                (sgn == SIGN_NEG && md_last_sign == SIGN_POS))
                md_step = md_step >> 1;
            md_last_sign = sgn;
            if (err > 0)
                md_delay = md_delay + DELAY_W'(md_step);
            else
                md_delay = md_delay - DELAY_W'(md_step);
            res.status      = ST_SEARCH;
            res.trials_done = md_trials;
        end
        res.antenna_delay  = md_delay;
        res.smoothed_range = md_average;
        return res;
    endfunction

    // Next random range: mostly ranges around the target while a search runs
    function automatic logic signed [RANGE_W-1:0] pick_range();
        int mag;
        int r;
        if (cf_mode && !md_finished && $urandom_range(0, 6) != 0) begin
            if ($urandom_range(0, 3) != 0)
                search_above = !search_above;
            mag = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3000);
            r   = search_above ? int'(cf_target) + mag : int'(cf_target) - mag;
            if (r > RANGE_MAX)
                r = int'(cf_target) - mag;
        end else if ($urandom_range(0, 1) == 0) begin
            r = $urandom();
        end else begin
            r = int'($urandom_range(0, 4000)) - 2000;
        end
        return RANGE_W'(r);
    endfunction

    function automatic t_stim_row row_range(input logic signed [RANGE_W-1:0] rng);
        t_stim_row row;
        row.is_cfg = 1'b0;
        row.addr   = CFG_MODE;
        row.data   = 0;
        row.rng    = rng;
        row.typed  = 1'b0;
        row.want   = '0;
        return row;
    endfunction

    function automatic t_stim_row row_check(input logic signed [RANGE_W-1:0] rng,
                                            input t_result want);
        t_stim_row row;
        row       = row_range(rng);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic t_stim_row row_cfg(input logic [CFG_A_W-1:0] addr,
                                          input int unsigned data);
        t_stim_row row;
        row        = row_range('0);
        row.is_cfg = 1'b1;
        row.addr   = addr;
        row.data   = data;
        return row;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Register write, only while nothing is in flight
    task automatic write_register(input logic [CFG_A_W-1:0] addr, input int unsigned data);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_addr    <= addr;
        i_cfg_wr_data <= CFG_D_W'(data);
        case (addr)
            CFG_MODE: begin
                cf_mode     = data[0];
                md_finished = 1'b0;
            end
            CFG_TARGET: cf_target = TARGET_W'(data);
            CFG_START:  cf_start  = DELAY_W'(data);
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one range and hold it until the transfer; valid stays up afterwards
    task automatic send_range(input logic signed [RANGE_W-1:0] rng, input bit typed,
                              input t_result want);
        t_result model;
        i_valid          <= 1'b1;
        i_measured_range <= rng;
        valid_up = 1'b1;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        model = next_calibration_result(rng);
        pending_results.push_back(typed ? want : model);
    endtask

    task automatic hold_sender(input int cycles);
        if (valid_up) begin
            i_valid <= 1'b0;
            valid_up = 1'b0;
        end
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain_results();
        hold_sender(0);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Receiver stall patterns, each held for a random stretch counted down in rx_left
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_style = t_rx_style'($urandom_range(0, 3));
            rx_left  = $urandom_range(20, 200);
        end
        rx_left--;
        rx_phase++;
        case (rx_style)
            RX_OPEN:   i_ready <= 1'b1;
            RX_COIN:   i_ready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: i_ready <= ($urandom_range(0, 4) == 0);
            default:   i_ready <= ((rx_phase % 5) < 3);
        endcase
    end

    // Result check against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result transfer with nothing pending");
            end else begin
                want = pending_results.pop_front();
                if (o_antenna_delay !== want.antenna_delay)
                    report_mismatch($sformatf("antenna_delay got %0d want %0d",
                                              o_antenna_delay, want.antenna_delay));
                if (o_smoothed_range !== want.smoothed_range)
                    report_mismatch($sformatf("smoothed_range got %0d want %0d",
                                              o_smoothed_range, want.smoothed_range));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_status, want.status));
                if (o_trials_done !== want.trials_done)
                    report_mismatch($sformatf("trials_done got %0d want %0d",
                                              o_trials_done, want.trials_done));
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_stim_row   dir_rows[$];
        int          sent;
        int          phase_len;
        int          burst_left;
        int          gap;
        int unsigned word;

        // Normal mode from reset: delay loaded, average extremes
        dir_rows.push_back(row_check(24'sd0, '{START_RST, 24'sd0, ST_NORMAL, 7'd0}));
        dir_rows.push_back(row_check(24'sh7FFFFF,
                                     '{START_RST, 24'sd4194303, ST_NORMAL, 7'd0}));
        dir_rows.push_back(row_check(24'sh800000,
                                     '{START_RST, -24'sd2097153, ST_NORMAL, 7'd0}));
        // Write past the register map, then extreme target and start
        dir_rows.push_back(row_cfg(CFG_UNUSED, 32'h007F_FFFF));
        dir_rows.push_back(row_cfg(CFG_TARGET, TARGET_MAX));
        dir_rows.push_back(row_cfg(CFG_START, 32'h007F_FFFF));
        dir_rows.push_back(row_cfg(CFG_MODE, 32'h007F_FFFF));
        // Zero error counts as not positive; average is held
        dir_rows.push_back(row_check(24'sh7FFFFF,
                                     '{16'd16500, -24'sd2097153, ST_SEARCH, 7'd0}));
        dir_rows.push_back(row_range(24'sh800000));
        // Sign flips halve the step down to a trial
        dir_rows.push_back(row_cfg(CFG_TARGET, 0));
        dir_rows.push_back(row_range(24'sd5));
        dir_rows.push_back(row_range(-24'sd5));
        dir_rows.push_back(row_range(24'sd0));
        dir_rows.push_back(row_range(24'sd1));
        dir_rows.push_back(row_range(-24'sd1));
        dir_rows.push_back(row_range(24'sd1));
        dir_rows.push_back(row_range(-24'sd1));
        dir_rows.push_back(row_range(24'sd1));
        dir_rows.push_back(row_check(24'sd77,
                                     '{16'd65535, -24'sd2097153, ST_TRIAL, 7'd1}));
        // Delay wraps upward, then downward
        dir_rows.push_back(row_check(24'sd1, '{16'd99, -24'sd2097153, ST_SEARCH, 7'd1}));
        dir_rows.push_back(row_cfg(CFG_START, 0));
        dir_rows.push_back(row_range(-24'sd1));
        dir_rows.push_back(row_range(-24'sd1));
        // Back to normal with a trial pending
        dir_rows.push_back(row_cfg(CFG_MODE, 32'h007F_FFFE));
        dir_rows.push_back(row_range(24'sd3));
        dir_rows.push_back(row_range(24'sh800000));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) begin
                drain_results();
                write_register(dir_rows[k].addr, dir_rows[k].data);
            end else begin
                send_range(dir_rows[k].rng, dir_rows[k].typed, dir_rows[k].want);
            end
        end

        // Random phases: new settings while idle, then bursts of ranges
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            drain_results();
            if ($urandom_range(0, 4) != 0) begin
                word    = $urandom();
                word[0] = ($urandom_range(0, 3) != 0);
                write_register(CFG_MODE, word);
            end
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 3))
                    0:       word = 0;
                    1:       word = TARGET_MAX;
                    2:       word = $urandom();
                    default: word = $urandom_range(0, 20000);
                endcase
                write_register(CFG_TARGET, word);
            end
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 3))
                    0:       word = 0;
                    1:       word = 32'h0000_FFFF;
                    2:       word = $urandom();
                    default: word = $urandom_range(10000, 30000);
                endcase
                write_register(CFG_START, word);
            end
            if ($urandom_range(0, 9) == 0)
                write_register(CFG_UNUSED, $urandom());

            phase_len  = $urandom_range(40, 220);
            burst_left = 0;
            for (int n = 0; n < phase_len; n++) begin
                if (burst_left == 0) begin
                    gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
                    if (gap != 0)
                        hold_sender(gap);
                    burst_left = $urandom_range(1, 24);
                end
                send_range(pick_range(), 1'b0, '0);
                burst_left--;
            end
            sent += phase_len;
        end

        drain_results();
        repeat (END_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/core/adsc_pkg.sv
rtl/core/adsc_cfg_regs.sv
rtl/core/adsc_update.sv
rtl/core/antenna_delay_search_calibrator.sv
tb/tb_antenna_delay_search_calibrator.sv
